// ----- rtl/source_byte_tokenizer_top_macros.svh -----
// Assertion macros for the source byte tokenizer checker.
// Used by sbt_checker.sv; no other dependencies.
`ifndef SOURCE_BYTE_TOKENIZER_TOP_MACROS_SVH
`define SOURCE_BYTE_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication
`define SBT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbt assertion failed");

// next-cycle implication
`define SBT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbt assertion failed");

`endif

// ----- rtl/sbt_pkg.sv -----
// Types and constants for the source byte tokenizer.
// No dependencies; used by sbt_scan, the top level and the checker.
package sbt_pkg;

   localparam int LineBits = 20;
   localparam int ColBits  = 16;

   localparam logic [4:0] KindWord     = 5'd0;
   localparam logic [4:0] KindNumber   = 5'd1;
   localparam logic [4:0] KindString   = 5'd2;
   localparam logic [4:0] KindNewline  = 5'd3;
   localparam logic [4:0] KindArrow    = 5'd4;
   localparam logic [4:0] KindLParen   = 5'd5;
   localparam logic [4:0] KindRParen   = 5'd6;
   localparam logic [4:0] KindLBracket = 5'd7;
   localparam logic [4:0] KindRBracket = 5'd8;
   localparam logic [4:0] KindLBrace   = 5'd9;
   localparam logic [4:0] KindRBrace   = 5'd10;
   localparam logic [4:0] KindColon    = 5'd11;
   localparam logic [4:0] KindComma    = 5'd12;
   localparam logic [4:0] KindEqual    = 5'd13;
   localparam logic [4:0] KindPlus     = 5'd14;
   localparam logic [4:0] KindMinus    = 5'd15;
   localparam logic [4:0] KindUnknown  = 5'd16;
   localparam logic [4:0] KindEof      = 5'd17;

   localparam logic [7:0] ChHash    = 8'h23;
   localparam logic [7:0] ChQuote   = 8'h22;
   localparam logic [7:0] ChNewline = 8'h0A;
   localparam logic [7:0] ChTab     = 8'h09;
   localparam logic [7:0] ChSpace   = 8'h20;
   localparam logic [7:0] ChUnder   = 8'h5F;
   localparam logic [7:0] ChLowerX  = 8'h78;
   localparam logic [7:0] ChGreater = 8'h3E;
   localparam logic [7:0] ChMinus   = 8'h2D;
   localparam logic [7:0] ChZero    = 8'h30;
   localparam logic [7:0] ChNul     = 8'h00;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [4:0]          token_kind;
      logic [31:0]         start_offset;
      logic [15:0]         token_length;
      logic [LineBits-1:0] start_line;
      logic [ColBits-1:0]  start_column;
      logic                last_of_run;
   } rsp_type;

   typedef enum logic [6:0] {
      MODE_IDLE          = 7'b0000001,
      MODE_WORD          = 7'b0000010,
      MODE_DEC           = 7'b0000100,
      MODE_HEX           = 7'b0001000,
      MODE_STRING        = 7'b0010000,
      MODE_LINE_COMMENT  = 7'b0100000,
      MODE_BLOCK_COMMENT = 7'b1000000
   } mode_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_SCAN   = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   typedef struct packed {
      mode_type            mode;
      logic [31:0]         offset;
      logic [LineBits-1:0] line;
      logic [ColBits-1:0]  column;
      logic [31:0]         tok_offset;
      logic [LineBits-1:0] tok_line;
      logic [ColBits-1:0]  tok_column;
      logic [15:0]         tok_count;
      logic [1:0]          hash_run;
   } scan_state_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    item0;
      rsp_type    item1;
   } emit_type;

   function automatic logic [4:0] symbol_kind(input logic [7:0] c);
      logic [4:0] k;
      unique case (c)
         8'h28:   k = KindLParen;
         8'h29:   k = KindRParen;
         8'h5B:   k = KindLBracket;
         8'h5D:   k = KindRBracket;
         8'h7B:   k = KindLBrace;
         8'h7D:   k = KindRBrace;
         8'h3A:   k = KindColon;
         8'h2C:   k = KindComma;
         8'h3D:   k = KindEqual;
         8'h2B:   k = KindPlus;
         8'h2D:   k = KindMinus;
         default: k = KindUnknown;
      endcase
      return k;
   endfunction

endpackage

// ----- rtl/sbt_scan.sv -----
// Scan step of the source byte tokenizer: one byte with two bytes of
// lookahead, or the end-of-input flush. Depends on sbt_pkg.
module sbt_scan (
   input  sbt_pkg::op_type         op,
   input  sbt_pkg::scan_state_type st,
   input  logic [7:0]              cur_byte,
   input  logic [7:0]              next_byte,
   input  logic [7:0]              after_byte,
   output sbt_pkg::scan_state_type st_next,
   output sbt_pkg::emit_type       emits
);

   logic        restart;
   logic        triple;
   logic        pend_valid;
   logic [4:0]  pend_kind;
   logic [15:0] pend_len;
   logic        new_valid;
   logic [4:0]  new_kind;
   logic [15:0] new_len;
   logic [15:0] cnt_inc;
   sbt_pkg::rsp_type pend_rsp;
   sbt_pkg::rsp_type new_rsp;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   assign cnt_inc = (st.tok_count != 16'hFFFF) ? st.tok_count + 16'd1 : st.tok_count;
   assign triple  = (cur_byte == sbt_pkg::ChHash) && (next_byte == sbt_pkg::ChHash) &&
                    (after_byte == sbt_pkg::ChHash);

   always_comb begin
      st_next    = st;
      restart    = 1'b0;
      pend_valid = 1'b0;
      pend_kind  = sbt_pkg::KindWord;
      pend_len   = st.tok_count;
      new_valid  = 1'b0;
      new_kind   = sbt_pkg::KindUnknown;
      new_len    = 16'd1;
      unique case (op)
         sbt_pkg::OP_SCAN: begin
            st_next.offset = st.offset + 32'd1;
            if (cur_byte == sbt_pkg::ChNewline) begin
               st_next.line   = (st.line != '1) ?
                                st.line + {{(sbt_pkg::LineBits-1){1'b0}}, 1'b1} : st.line;
               st_next.column = {{(sbt_pkg::ColBits-1){1'b0}}, 1'b1};
            end else begin
               st_next.column = (st.column != '1) ?
                                st.column + {{(sbt_pkg::ColBits-1){1'b0}}, 1'b1} : st.column;
            end
            if (st.hash_run != 2'd0) begin
               st_next.hash_run = st.hash_run - 2'd1;
            end else begin
               unique case (st.mode)
                  sbt_pkg::MODE_WORD: begin
                     if (is_alpha(cur_byte) || is_digit(cur_byte) ||
                         cur_byte == sbt_pkg::ChUnder) begin
                        st_next.tok_count = cnt_inc;
                     end else begin
                        pend_valid = 1'b1;
                        restart    = 1'b1;
                     end
                  end
                  sbt_pkg::MODE_DEC: begin
                     if (is_digit(cur_byte)) begin
                        st_next.tok_count = cnt_inc;
                     end else begin
                        pend_valid = 1'b1;
                        pend_kind  = sbt_pkg::KindNumber;
                        restart    = 1'b1;
                     end
                  end
                  sbt_pkg::MODE_HEX: begin
                     if (is_hex(cur_byte)) begin
                        st_next.tok_count = cnt_inc;
                     end else begin
                        pend_valid = 1'b1;
                        pend_kind  = sbt_pkg::KindNumber;
                        restart    = 1'b1;
                     end
                  end
                  sbt_pkg::MODE_STRING: begin
                     st_next.tok_count = cnt_inc;
                     if (cur_byte == sbt_pkg::ChQuote) begin
                        pend_valid   = 1'b1;
                        pend_kind    = sbt_pkg::KindString;
                        pend_len     = cnt_inc;
                        st_next.mode = sbt_pkg::MODE_IDLE;
                     end
                  end
                  sbt_pkg::MODE_LINE_COMMENT: begin
                     restart = (cur_byte == sbt_pkg::ChNewline);
                  end
                  sbt_pkg::MODE_BLOCK_COMMENT: begin
                     if (triple) begin
                        st_next.hash_run = 2'd2;
                        st_next.mode     = sbt_pkg::MODE_IDLE;
                     end
                  end
                  default: begin
                     restart = 1'b1;
                  end
               endcase
               if (restart) begin
                  st_next.mode       = sbt_pkg::MODE_IDLE;
                  st_next.tok_offset = st.offset;
                  st_next.tok_line   = st.line;
                  st_next.tok_column = st.column;
                  st_next.tok_count  = 16'd1;
                  priority if (cur_byte == sbt_pkg::ChHash) begin
                     if (triple) begin
                        st_next.mode     = sbt_pkg::MODE_BLOCK_COMMENT;
                        st_next.hash_run = 2'd2;
                     end else begin
                        st_next.mode = sbt_pkg::MODE_LINE_COMMENT;
                     end
                  end else if (cur_byte == sbt_pkg::ChQuote) begin
                     st_next.mode = sbt_pkg::MODE_STRING;
                  end else if (cur_byte == sbt_pkg::ChNewline) begin
                     new_valid = 1'b1;
                     new_kind  = sbt_pkg::KindNewline;
                  end else if (cur_byte == sbt_pkg::ChMinus &&
                               next_byte == sbt_pkg::ChGreater) begin
                     new_valid        = 1'b1;
                     new_kind         = sbt_pkg::KindArrow;
                     new_len          = 16'd2;
                     st_next.hash_run = 2'd1;
                  end else if (is_digit(cur_byte)) begin
                     if (cur_byte == sbt_pkg::ChZero && next_byte == sbt_pkg::ChLowerX) begin
                        st_next.mode      = sbt_pkg::MODE_HEX;
                        st_next.tok_count = 16'd2;
                        st_next.hash_run  = 2'd1;
                     end else begin
                        st_next.mode = sbt_pkg::MODE_DEC;
                     end
                  end else if (is_alpha(cur_byte) || cur_byte == sbt_pkg::ChUnder) begin
                     st_next.mode = sbt_pkg::MODE_WORD;
                  end else if (cur_byte != sbt_pkg::ChSpace && cur_byte != sbt_pkg::ChTab) begin
                     new_valid = 1'b1;
                     new_kind  = sbt_pkg::symbol_kind(cur_byte);
                  end
               end
            end
         end
         sbt_pkg::OP_FINISH: begin
            unique case (st.mode)
               sbt_pkg::MODE_WORD: begin
                  pend_valid = 1'b1;
               end
               sbt_pkg::MODE_DEC, sbt_pkg::MODE_HEX: begin
                  pend_valid = 1'b1;
                  pend_kind  = sbt_pkg::KindNumber;
               end
               sbt_pkg::MODE_STRING: begin
                  // unterminated: closing quote counted as present
                  pend_valid = 1'b1;
                  pend_kind  = sbt_pkg::KindString;
                  pend_len   = cnt_inc;
               end
               default: begin
                  pend_valid = 1'b0;
               end
            endcase
            st_next.mode     = sbt_pkg::MODE_IDLE;
            st_next.hash_run = 2'd0;
            new_valid        = 1'b1;
            new_kind         = sbt_pkg::KindEof;
            new_len          = 16'd0;
         end
         default: begin
            st_next = st;
         end
      endcase
   end

   always_comb begin
      pend_rsp.token_kind   = pend_kind;
      pend_rsp.start_offset = st.tok_offset;
      pend_rsp.token_length = pend_len;
      pend_rsp.start_line   = st.tok_line;
      pend_rsp.start_column = st.tok_column;
      pend_rsp.last_of_run  = 1'b0;
      new_rsp.token_kind    = new_kind;
      new_rsp.start_offset  = st.offset;
      new_rsp.token_length  = new_len;
      new_rsp.start_line    = st.line;
      new_rsp.start_column  = st.column;
      new_rsp.last_of_run   = 1'b0;
      emits.count = {1'b0, pend_valid} + {1'b0, new_valid};
      emits.item0 = pend_valid ? pend_rsp : new_rsp;
      emits.item1 = new_rsp;
   end

endmodule

// ----- rtl/source_byte_tokenizer_top.sv -----
// Source byte tokenizer, top level: input register, lookahead, scan step
// and a four-entry result queue. Depends on sbt_pkg and sbt_scan.
//
// One source byte is taken per clock while the input side does not stall.
// A byte is scanned two transfers after it arrives (two bytes of lookahead),
// and the scan step of one byte yields at most two tokens, which go into a
// four-entry result queue drained one token per clock while the receiver is
// ready; the input side stalls while that queue holds three or more tokens
// and during the end-of-input steps. An end-of-input transfer (end flag or
// zero byte) starts two lookahead drain steps and the final flush with the
// end-of-file token. After that, transfers are taken and dropped until
// reset.
module source_byte_tokenizer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sbt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sbt_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      PH_RUN    = 4'b0001,
      PH_TAIL   = 4'b0010,
      PH_FINISH = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic                     in_valid_ff, in_valid_in;
   sbt_pkg::req_type         in_ff, in_in;
   logic [7:0]               la0_ff, la0_in, la1_ff, la1_in;
   logic [1:0]               la_cnt_ff, la_cnt_in;
   sbt_pkg::scan_state_type  scan_ff, scan_in;
   sbt_pkg::rsp_type         mem_ff [4];
   logic [1:0]               wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0]               count_ff, count_in;

   sbt_pkg::op_type   op;
   sbt_pkg::emit_type emits;
   sbt_pkg::rsp_type  push0, push1;
   logic [7:0]        cur_byte, next_byte, after_byte;
   logic              room, is_end, consume, drain, mark_last, pop;

   assign room   = (count_ff <= 3'd2);
   assign is_end = in_ff.end_of_input || (in_ff.source_byte == sbt_pkg::ChNul);

   always_comb begin
      phase_in   = phase_ff;
      la0_in     = la0_ff;
      la1_in     = la1_ff;
      la_cnt_in  = la_cnt_ff;
      op         = sbt_pkg::OP_NONE;
      cur_byte   = la0_ff;
      next_byte  = la1_ff;
      after_byte = in_ff.source_byte;
      consume    = 1'b0;
      drain      = 1'b0;
      mark_last  = 1'b1;
      unique case (phase_ff)
         PH_RUN: begin
            if (in_valid_ff && room) begin
               consume = 1'b1;
               if (!is_end) begin
                  if (la_cnt_ff != 2'd2) begin
                     if (la_cnt_ff == 2'd0) begin
                        la0_in = in_ff.source_byte;
                     end else begin
                        la1_in = in_ff.source_byte;
                     end
                     la_cnt_in = la_cnt_ff + 2'd1;
                  end else begin
                     op     = sbt_pkg::OP_SCAN;
                     la0_in = la1_ff;
                     la1_in = in_ff.source_byte;
                  end
               end else begin
                  drain    = 1'b1;
                  phase_in = PH_TAIL;
               end
            end
         end
         PH_TAIL: begin
            if (room) begin
               drain    = 1'b1;
               phase_in = PH_FINISH;
            end
         end
         PH_FINISH: begin
            if (room) begin
               op       = sbt_pkg::OP_FINISH;
               phase_in = PH_DONE;
            end
         end
         default: begin
            consume = in_valid_ff;
         end
      endcase
      if (drain) begin
         mark_last  = 1'b0;
         op         = (la_cnt_ff != 2'd0) ? sbt_pkg::OP_SCAN : sbt_pkg::OP_NONE;
         next_byte  = (la_cnt_ff == 2'd2) ? la1_ff : sbt_pkg::ChNul;
         after_byte = sbt_pkg::ChNul;
         la0_in     = la1_ff;
         la1_in     = sbt_pkg::ChNul;
         la_cnt_in  = (la_cnt_ff != 2'd0) ? la_cnt_ff - 2'd1 : 2'd0;
      end
   end

   sbt_scan u_scan (
      .op         (op),
      .st         (scan_ff),
      .cur_byte   (cur_byte),
      .next_byte  (next_byte),
      .after_byte (after_byte),
      .st_next    (scan_in),
      .emits      (emits)
   );

   assign req_ready = !in_valid_ff || consume;

   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_in       = req_data;
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      push0             = emits.item0;
      push1             = emits.item1;
      push0.last_of_run = mark_last && (emits.count == 2'd1);
      push1.last_of_run = mark_last;
      wr_ptr_in = wr_ptr_ff + emits.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, emits.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (emits.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (emits.count == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= push1;
      end
      in_ff <= in_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_RUN;
         in_valid_ff         <= 1'b0;
         la0_ff              <= '0;
         la1_ff              <= '0;
         la_cnt_ff           <= '0;
         wr_ptr_ff           <= '0;
         rd_ptr_ff           <= '0;
         count_ff            <= '0;
         scan_ff.mode        <= sbt_pkg::MODE_IDLE;
         scan_ff.offset      <= '0;
         scan_ff.line        <= {{(sbt_pkg::LineBits-1){1'b0}}, 1'b1};
         scan_ff.column      <= {{(sbt_pkg::ColBits-1){1'b0}}, 1'b1};
         scan_ff.tok_offset  <= '0;
         scan_ff.tok_line    <= {{(sbt_pkg::LineBits-1){1'b0}}, 1'b1};
         scan_ff.tok_column  <= {{(sbt_pkg::ColBits-1){1'b0}}, 1'b1};
         scan_ff.tok_count   <= '0;
         scan_ff.hash_run    <= '0;
      end else begin
         phase_ff    <= phase_in;
         in_valid_ff <= in_valid_in;
         la0_ff      <= la0_in;
         la1_ff      <= la1_in;
         la_cnt_ff   <= la_cnt_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         scan_ff     <= scan_in;
      end
   end

endmodule

// ----- rtl/sbt_checker.sv -----
// Port-level checker for the source byte tokenizer, bound to the top level.
// Depends on sbt_pkg and source_byte_tokenizer_top_macros.svh.
`include "source_byte_tokenizer_top_macros.svh"

module sbt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sbt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sbt_pkg::rsp_type rsp_data
);

   logic eof_xfer;

   assign eof_xfer = rsp_valid && rsp_ready && (rsp_data.token_kind == sbt_pkg::KindEof);

   `SBT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `SBT_ASSERT_NXT(a_quiet_after_eof, clock, reset, eof_xfer, !rsp_valid)
   `SBT_ASSERT_IMP(a_eof_shape, clock, reset, rsp_valid && rsp_data.token_kind == sbt_pkg::KindEof, rsp_data.last_of_run && rsp_data.token_length == 16'd0)
   `SBT_ASSERT_IMP(a_arrow_len, clock, reset, rsp_valid && rsp_data.token_kind == sbt_pkg::KindArrow, rsp_data.token_length == 16'd2)
   `SBT_ASSERT_IMP(a_kind_range, clock, reset, rsp_valid, rsp_data.token_kind <= sbt_pkg::KindEof)

endmodule

bind source_byte_tokenizer_top sbt_checker u_sbt_checker (.*);

// ----- tb/sv/testbench.sv -----
// Testbench for source_byte_tokenizer_top: a directed table and random source
// text go through one tokenizer stream, and every token is checked against the
// table or an inline scanner. Depends on sbt_pkg and the tokenizer RTL only.
`timescale 1ns / 100ps

module testbench;

   localparam int HoldCycles = 150;
   localparam int TimeoutNs  = 200_000;

   localparam string WordChars =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
   localparam string HexChars   = "0123456789abcdefABCDEF";
   localparam string Punct      = "()[]{}:,=+-";
   localparam string OddChars   = "!$%&*./;<?@^`|~";
   localparam string NoteChars  = "abc xyz_019\t";

   typedef struct {
      logic [7:0]       ch;
      bit               typed;
      sbt_pkg::rsp_type want;
   } script_row_type;

   logic             clock        = 1'b0;
   logic             reset        = 1'b1;
   logic             req_valid    = 1'b0;
   logic             req_ready;
   sbt_pkg::req_type req_data     = '0;
   logic             rsp_valid;
   logic             rsp_ready    = 1'b0;
   sbt_pkg::rsp_type rsp_data;
   logic             hold_request = 1'b0;

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int transfers_in   = 0;
   int tokens_checked = 0;
   int failures       = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   logic [31:0] kinds_seen = '0;

   // scanner state
   logic [7:0]                   la_byte [2] = '{8'h00, 8'h00};
   int                           la_count    = 0;
   sbt_pkg::mode_type            scan_st     = sbt_pkg::MODE_IDLE;
   logic [31:0]                  cur_off     = '0;
   logic [sbt_pkg::LineBits-1:0] cur_line    = 1;
   logic [sbt_pkg::ColBits-1:0]  cur_col     = 1;
   logic [31:0]                  tok_off     = '0;
   logic [sbt_pkg::LineBits-1:0] tok_line    = 1;
   logic [sbt_pkg::ColBits-1:0]  tok_col     = 1;
   logic [15:0]                  tok_len     = '0;
   int                           swallow     = 0;
   bit                           stream_done = 1'b0;

   sbt_pkg::rsp_type step_tokens[$];
   sbt_pkg::rsp_type expected_tokens[$];
   logic [7:0]       pending_text[$];
   script_row_type   script[$];

   always #2 clock = ~clock;

   source_byte_tokenizer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function automatic void add_byte(logic [7:0] c);
      pending_text.insert(pending_text.size(), c);
   endfunction

   function automatic void add_expected(sbt_pkg::rsp_type t);
      expected_tokens.insert(expected_tokens.size(), t);
   endfunction

   function automatic void add_row(script_row_type r);
      script.insert(script.size(), r);
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [4:0] punct_kind(logic [7:0] c);
      logic [4:0] k;
      case (c)
         "(":              k = sbt_pkg::KindLParen;
         ")":              k = sbt_pkg::KindRParen;
         "[":              k = sbt_pkg::KindLBracket;
         "]":              k = sbt_pkg::KindRBracket;
         "{":              k = sbt_pkg::KindLBrace;
         "}":              k = sbt_pkg::KindRBrace;
         ":":              k = sbt_pkg::KindColon;
         ",":              k = sbt_pkg::KindComma;
         "=":              k = sbt_pkg::KindEqual;
         "+":              k = sbt_pkg::KindPlus;
         sbt_pkg::ChMinus: k = sbt_pkg::KindMinus;
         default:          k = sbt_pkg::KindUnknown;
      endcase
      return k;
   endfunction

   function automatic logic [15:0] grown(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic void push_token(logic [4:0] kind, logic [31:0] off, logic [15:0] len,
                                      logic [sbt_pkg::LineBits-1:0] line,
                                      logic [sbt_pkg::ColBits-1:0] col);
      sbt_pkg::rsp_type t;
      if (step_tokens.size() >= 4) return;
      t.token_kind   = kind;
      t.start_offset = off;
      t.token_length = len;
      t.start_line   = line;
      t.start_column = col;
      t.last_of_run  = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
   endfunction

   function automatic void push_pending(logic [4:0] kind, logic [15:0] len);
      push_token(kind, tok_off, len, tok_line, tok_col);
   endfunction

   function automatic void advance_pos(logic [7:0] c);
      cur_off = cur_off + 32'd1;
      if (c == sbt_pkg::ChNewline) begin
         if (cur_line != '1) cur_line = cur_line + 1'b1;
         cur_col = 1;
      end else if (cur_col != '1) begin
         cur_col = cur_col + 1'b1;
      end
   endfunction

   // scans byte c with lookahead p, q
   function automatic void scan_char(logic [7:0] c, logic [7:0] p, logic [7:0] q);
      if (swallow > 0) begin
         swallow--;
         advance_pos(c);
         return;
      end
      case (scan_st)
         sbt_pkg::MODE_WORD: begin
            if (is_alpha(c) || is_digit(c) || c == sbt_pkg::ChUnder) begin
               tok_len = grown(tok_len);
               advance_pos(c);
               return;
            end
            push_pending(sbt_pkg::KindWord, tok_len);
         end
         sbt_pkg::MODE_DEC: begin
            if (is_digit(c)) begin
               tok_len = grown(tok_len);
               advance_pos(c);
               return;
            end
            push_pending(sbt_pkg::KindNumber, tok_len);
         end
         sbt_pkg::MODE_HEX: begin
            if (is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
               tok_len = grown(tok_len);
               advance_pos(c);
               return;
            end
            push_pending(sbt_pkg::KindNumber, tok_len);
         end
         sbt_pkg::MODE_STRING: begin
            tok_len = grown(tok_len);
            if (c == sbt_pkg::ChQuote) begin
               push_pending(sbt_pkg::KindString, tok_len);
               scan_st = sbt_pkg::MODE_IDLE;
            end
            advance_pos(c);
            return;
         end
         sbt_pkg::MODE_LINE_COMMENT: begin
            if (c != sbt_pkg::ChNewline) begin
               advance_pos(c);
               return;
            end
         end
         sbt_pkg::MODE_BLOCK_COMMENT: begin
            if (c == sbt_pkg::ChHash && p == sbt_pkg::ChHash && q == sbt_pkg::ChHash) begin
               swallow = 2;
               scan_st = sbt_pkg::MODE_IDLE;
            end
            advance_pos(c);
            return;
         end
         default: ;
      endcase
      scan_st  = sbt_pkg::MODE_IDLE;
      tok_off  = cur_off;
      tok_line = cur_line;
      tok_col  = cur_col;
      tok_len  = 16'd1;
      if (c == sbt_pkg::ChHash) begin
         if (p == sbt_pkg::ChHash && q == sbt_pkg::ChHash) begin
            scan_st = sbt_pkg::MODE_BLOCK_COMMENT;
            swallow = 2;
         end else begin
            scan_st = sbt_pkg::MODE_LINE_COMMENT;
         end
      end else if (c == sbt_pkg::ChQuote) begin
         scan_st = sbt_pkg::MODE_STRING;
      end else if (c == sbt_pkg::ChSpace || c == sbt_pkg::ChTab) begin
      end else if (c == sbt_pkg::ChNewline) begin
         push_pending(sbt_pkg::KindNewline, 16'd1);
      end else if (c == sbt_pkg::ChMinus && p == sbt_pkg::ChGreater) begin
         push_pending(sbt_pkg::KindArrow, 16'd2);
         swallow = 1;
      end else if (is_digit(c)) begin
         if (c == sbt_pkg::ChZero && p == sbt_pkg::ChLowerX) begin
            scan_st = sbt_pkg::MODE_HEX;
            tok_len = 16'd2;
            swallow = 1;
         end else begin
            scan_st = sbt_pkg::MODE_DEC;
         end
      end else if (is_alpha(c) || c == sbt_pkg::ChUnder) begin
         scan_st = sbt_pkg::MODE_WORD;
      end else begin
         push_pending(punct_kind(c), 16'd1);
      end
      advance_pos(c);
   endfunction

   // fills step_tokens with the tokens one accepted transfer produces
   function automatic void predict_tokens(sbt_pkg::req_type item);
      step_tokens.delete();
      if (!stream_done) begin
         if (!item.end_of_input && item.source_byte != sbt_pkg::ChNul) begin
            if (la_count < 2) begin
               la_byte[la_count] = item.source_byte;
               la_count++;
            end else begin
               scan_char(la_byte[0], la_byte[1], item.source_byte);
               la_byte[0] = la_byte[1];
               la_byte[1] = item.source_byte;
            end
         end else begin
            if (la_count >= 1)
               scan_char(la_byte[0], (la_count == 2) ? la_byte[1] : sbt_pkg::ChNul,
                         sbt_pkg::ChNul);
            if (la_count == 2)
               scan_char(la_byte[1], sbt_pkg::ChNul, sbt_pkg::ChNul);
            swallow = 0;
            case (scan_st)
               sbt_pkg::MODE_WORD:
                  push_pending(sbt_pkg::KindWord, tok_len);
               sbt_pkg::MODE_DEC, sbt_pkg::MODE_HEX:
                  push_pending(sbt_pkg::KindNumber, tok_len);
               sbt_pkg::MODE_STRING:
                  push_pending(sbt_pkg::KindString, grown(tok_len));
               default: ;
            endcase
            scan_st = sbt_pkg::MODE_IDLE;
            push_token(sbt_pkg::KindEof, cur_off, 16'd0, cur_line, cur_col);
            la_count    = 0;
            la_byte[0]  = sbt_pkg::ChNul;
            la_byte[1]  = sbt_pkg::ChNul;
            stream_done = 1'b1;
         end
      end
      if (step_tokens.size() > 0)
         step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
   endfunction

   function automatic void record(sbt_pkg::req_type item);
      predict_tokens(item);
      foreach (step_tokens[i]) add_expected(step_tokens[i]);
   endfunction

   function automatic logic [7:0] pick_char(string set);
      return set[$urandom_range(set.len() - 1)];
   endfunction

   // appends random well-formed fragments, with some noise
   function automatic void compose_text(int nbytes);
      int n;
      while (pending_text.size() < nbytes) begin
         case ($urandom_range(15))
            0, 1: begin
               add_byte($urandom_range(1) ? sbt_pkg::ChUnder : pick_char(WordChars) | 8'h40);
               repeat ($urandom_range(6)) add_byte(pick_char(WordChars));
            end
            2: repeat ($urandom_range(5, 1)) add_byte(pick_char("0123456789"));
            3: begin
               add_byte(sbt_pkg::ChZero);
               add_byte(sbt_pkg::ChLowerX);
               repeat ($urandom_range(4)) add_byte(pick_char(HexChars));
            end
            4: begin
               add_byte(sbt_pkg::ChQuote);
               n = $urandom_range(6);
               repeat (n) add_byte($urandom_range(1) ? pick_char(NoteChars)
                                                     : 8'($urandom_range(255, 128)));
               add_byte(sbt_pkg::ChQuote);
            end
            5: begin
               add_byte(sbt_pkg::ChHash);
               repeat ($urandom_range(5)) add_byte(pick_char(NoteChars));
               add_byte(sbt_pkg::ChNewline);
            end
            6: begin
               repeat (3) add_byte(sbt_pkg::ChHash);
               repeat ($urandom_range(6)) add_byte(pick_char("ab ()\n\"-"));
               repeat (3) add_byte(sbt_pkg::ChHash);
            end
            7: add_byte(pick_char(Punct));
            8: begin
               add_byte(sbt_pkg::ChMinus);
               add_byte(sbt_pkg::ChGreater);
            end
            9: repeat ($urandom_range(3, 1)) add_byte($urandom_range(1) ? sbt_pkg::ChSpace
                                                                        : sbt_pkg::ChTab);
            10: add_byte(sbt_pkg::ChNewline);
            11: add_byte($urandom_range(1) ? pick_char(OddChars)
                                           : 8'($urandom_range(255, 128)));
            12: add_byte(8'($urandom_range(255, 1)));
            13: begin
               add_byte(sbt_pkg::ChZero);
               add_byte("X");
               add_byte(pick_char(HexChars));
            end
            default: add_byte(sbt_pkg::ChSpace);
         endcase
      end
   endfunction

   function automatic script_row_type plain(logic [7:0] c);
      script_row_type r;
      r.ch    = c;
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic script_row_type token_row(logic [7:0] c, logic [4:0] kind,
                                                logic [31:0] off, logic [15:0] len,
                                                logic [sbt_pkg::ColBits-1:0] col);
      script_row_type r;
      r.ch                = c;
      r.typed             = 1'b1;
      r.want.token_kind   = kind;
      r.want.start_offset = off;
      r.want.token_length = len;
      r.want.start_line   = 1;
      r.want.start_column = col;
      r.want.last_of_run  = 1'b1;
      return r;
   endfunction

   task automatic offer(sbt_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      transfers_in++;
   endtask

   task automatic send_text();
      sbt_pkg::req_type item;
      foreach (pending_text[i]) begin
         item.source_byte  = pending_text[i];
         item.end_of_input = 1'b0;
         offer(item);
         record(item);
      end
      pending_text.delete();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   function automatic void check_token(sbt_pkg::rsp_type got);
      sbt_pkg::rsp_type want;
      if (expected_tokens.size() == 0) begin
         $error("unexpected token: kind %0d offset %0d", got.token_kind, got.start_offset);
         failures++;
         return;
      end
      want = expected_tokens.pop_front();
      tokens_checked++;
      kinds_seen[got.token_kind] = 1'b1;
      if (got.token_kind !== want.token_kind) begin
         $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
         failures++;
      end
      if (got.start_offset !== want.start_offset) begin
         $error("start_offset: expected %0d, got %0d", want.start_offset, got.start_offset);
         failures++;
      end
      if (got.token_length !== want.token_length) begin
         $error("token_length: expected %0d, got %0d", want.token_length, got.token_length);
         failures++;
      end
      if (got.start_line !== want.start_line) begin
         $error("start_line: expected %0d, got %0d", want.start_line, got.start_line);
         failures++;
      end
      if (got.start_column !== want.start_column) begin
         $error("start_column: expected %0d, got %0d", want.start_column, got.start_column);
         failures++;
      end
      if (got.last_of_run !== want.last_of_run) begin
         $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
         failures++;
      end
   endfunction

   // result side: check transfers, random stalls, one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_token(rsp_data);
      if (hold_request && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      sbt_pkg::req_type item;

      add_row(plain("("));
      add_row(plain(")"));
      add_row(token_row("[", sbt_pkg::KindLParen, 0, 1, 1));
      add_row(token_row("]", sbt_pkg::KindRParen, 1, 1, 2));
      add_row(token_row("{", sbt_pkg::KindLBracket, 2, 1, 3));
      add_row(token_row("}", sbt_pkg::KindRBracket, 3, 1, 4));
      add_row(token_row(":", sbt_pkg::KindLBrace, 4, 1, 5));
      add_row(token_row(",", sbt_pkg::KindRBrace, 5, 1, 6));
      add_row(token_row("=", sbt_pkg::KindColon, 6, 1, 7));
      add_row(token_row("+", sbt_pkg::KindComma, 7, 1, 8));
      add_row(token_row(sbt_pkg::ChMinus, sbt_pkg::KindEqual, 8, 1, 9));
      add_row(token_row(sbt_pkg::ChGreater, sbt_pkg::KindPlus, 9, 1, 10));
      add_row(token_row(8'hFF, sbt_pkg::KindArrow, 10, 2, 11));
      add_row(plain(sbt_pkg::ChNewline));
      add_row(token_row(sbt_pkg::ChHash, sbt_pkg::KindUnknown, 12, 1, 13));
      add_row(token_row(sbt_pkg::ChHash, sbt_pkg::KindNewline, 13, 1, 14));
      add_row(plain(sbt_pkg::ChHash));
      add_row(plain(sbt_pkg::ChTab));
      add_row(plain("1"));
      add_row(plain(sbt_pkg::ChHash));
      add_row(plain(sbt_pkg::ChHash));
      add_row(plain(sbt_pkg::ChHash));
      add_row(plain(sbt_pkg::ChZero));
      add_row(plain(sbt_pkg::ChLowerX));
      add_row(plain(sbt_pkg::ChSpace));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 19;
      recv_idle_pct = 67;
      foreach (script[i]) begin
         item.source_byte  = script[i].ch;
         item.end_of_input = 1'b0;
         offer(item);
         predict_tokens(item);
         if (script[i].typed)
            add_expected(script[i].want);
         else
            foreach (step_tokens[k]) add_expected(step_tokens[k]);
      end
      compose_text(35);
      send_text();
      drain();

      send_idle_pct = 67;
      recv_idle_pct = 19;
      compose_text(35);
      send_text();
      drain();

      // fill the result queue against a held-off receiver
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request <= 1'b1;
      repeat (25) add_byte(pick_char(Punct));
      send_text();
      drain();

      // random text, then a token or block comment left open at the end of input
      compose_text(10);
      add_byte(sbt_pkg::ChSpace);
      case ($urandom_range(3))
         0: begin
            add_byte(sbt_pkg::ChQuote);
            add_byte("a");
            add_byte("b");
         end
         1: begin
            add_byte("e");
            add_byte(sbt_pkg::ChUnder);
         end
         2: begin
            add_byte(sbt_pkg::ChZero);
            add_byte(sbt_pkg::ChLowerX);
            add_byte("7");
         end
         default: begin
            repeat (3) add_byte(sbt_pkg::ChHash);
            add_byte("z");
         end
      endcase
      send_text();

      if ($urandom_range(1)) begin
         item.source_byte  = sbt_pkg::ChNul;
         item.end_of_input = 1'b0;
      end else begin
         item.source_byte  = 8'($urandom_range(255));
         item.end_of_input = 1'b1;
      end
      offer(item);
      record(item);

      // everything after the end is dropped
      repeat (4) begin
         item.source_byte  = 8'($urandom_range(255));
         item.end_of_input = 1'($urandom_range(1));
         offer(item);
         record(item);
      end

      drain();
      repeat (10) @(posedge clock);
      $display("covered %0d input transfers, %0d tokens checked, %0d of 18 token kinds",
               transfers_in, tokens_checked, $countones(kinds_seen));
      $display("with three idle mixes, a %0d-cycle receiver hold-off and an end-of-input flush",
               HoldCycles);
      if (failures == 0 && expected_tokens.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(TimeoutNs);
      $error("timeout with %0d tokens outstanding", expected_tokens.size());
      $display("status: fail");
      $finish;
   end

endmodule
